[src/upe_pkg.sv]
// Shared types, escape tables and character constants for the URI percent escaper.
`timescale 1ns / 1ps

package upe_pkg;

    // Escape mode codes as written to the configuration register.
    localparam logic [2:0] MODE_URI       = 3'd0;
    localparam logic [2:0] MODE_ARGS      = 3'd1;
    localparam logic [2:0] MODE_URI_COMP  = 3'd2;
    localparam logic [2:0] MODE_HTML      = 3'd3;
    localparam logic [2:0] MODE_REFRESH   = 3'd4;
    localparam logic [2:0] MODE_MEMCACHED = 3'd5;
    localparam logic [2:0] MODE_MAIL_AUTH = 3'd6;

    localparam int NUM_TABLES = 6;
    localparam logic [2:0] ROW_MEMCACHED = 3'd5;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    // One bit per byte value; bit b set means byte b is escaped.
    typedef logic [255:0] esc_table_t;

    // Rows are written as words 7 down to 0, 32 byte values per word.
    localparam esc_table_t ESC_TABLES [NUM_TABLES] = '{
        {32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
         32'h80000000, 32'h00000000, 32'h80000029, 32'hffffffff},
        {32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
         32'h80000000, 32'h00000000, 32'h88000869, 32'hffffffff},
        {32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
         32'hb8000001, 32'h78000001, 32'hfc009fff, 32'hffffffff},
        {32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
         32'h80000000, 32'h00000000, 32'h000000ad, 32'hffffffff},
        {32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
         32'h80000000, 32'h00000000, 32'h00000085, 32'hffffffff},
        {32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
         32'h00000000, 32'h00000000, 32'h00000021, 32'hffffffff}
    };

    // Lower-case hex digit characters.
    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    // Result of classifying one input byte.
    typedef struct packed {
        logic       hit;
        logic [7:0] hi_digit;
        logic [7:0] lo_digit;
    } class_t;

    // One input word with its classification, handed to the output stage.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_in;
        class_t     cls;
    } item_t;

    // Maps an escape mode to its table row; mail auth and the unused code share memcached.
    function automatic logic [2:0] table_row(input logic [2:0] mode);
        logic [2:0] row;
        case (mode)
            MODE_URI:      row = 3'd0;
            MODE_ARGS:     row = 3'd1;
            MODE_URI_COMP: row = 3'd2;
            MODE_HTML:     row = 3'd3;
            MODE_REFRESH:  row = 3'd4;
            default:       row = ROW_MEMCACHED;
        endcase
        return row;
    endfunction

endpackage

[src/upe_classify.sv]
// Table lookup and hex digit generation for one input byte.
`timescale 1ns / 1ps

module upe_classify (
    input  logic [2:0]          escape_mode,
    input  logic [7:0]          in_byte,
    output upe_pkg::class_t     cls
);
    import upe_pkg::*;

    logic [2:0] row;

    // Pick the table row, test the byte's bit, and form both hex digits.
    always_comb begin
        row          = table_row(escape_mode);
        cls.hit      = ESC_TABLES[row][in_byte];
        cls.hi_digit = HEX_DIGITS[in_byte[7:4]];
        cls.lo_digit = HEX_DIGITS[in_byte[3:0]];
    end

endmodule

[src/upe_out_stage.sv]
// Output register, one word per cycle while m_tready is high, 3 per escaped byte.
`timescale 1ns / 1ps

module upe_out_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ld_valid,
    input  upe_pkg::item_t  ld_item,
    output logic            ld_ready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,   // out_byte [7:0]
    output logic            m_tlast,   // last_of_run
    output logic [0:0]      m_tuser    // end_of_text [0]
);
    import upe_pkg::*;

    logic       valid_reg, valid_next;
    logic [1:0] rem_reg, rem_next;
    logic [7:0] byte_reg, byte_next;
    logic       lor_reg, lor_next;
    logic       eot_reg, eot_next;
    logic [7:0] hi_reg, hi_next;
    logic [7:0] lo_reg, lo_next;
    logic       last_reg, last_next;
    logic       take;

    assign take     = valid_reg && m_tready;
    assign ld_ready = !valid_reg || (take && (rem_reg == 2'd0));

    // Load a new item, step through the escape sequence, or go empty.
    always_comb begin
        valid_next = valid_reg;
        rem_next   = rem_reg;
        byte_next  = byte_reg;
        lor_next   = lor_reg;
        eot_next   = eot_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        last_next  = last_reg;
        if (take && (rem_reg != 2'd0)) begin
            rem_next = rem_reg - 2'd1;
            if (rem_reg == 2'd2) begin
                byte_next = hi_reg;
            end else begin
                byte_next = lo_reg;
                lor_next  = 1'b1;
                eot_next  = last_reg;
            end
        end else if (ld_ready) begin
            valid_next = ld_valid;
            hi_next    = ld_item.cls.hi_digit;
            lo_next    = ld_item.cls.lo_digit;
            last_next  = ld_item.last_in;
            if (ld_item.cls.hit) begin
                rem_next  = 2'd2;
                byte_next = PCT_CHAR;
                lor_next  = 1'b0;
                eot_next  = 1'b0;
            end else begin
                rem_next  = 2'd0;
                byte_next = ld_item.in_byte;
                lor_next  = 1'b1;
                eot_next  = ld_item.last_in;
            end
        end
    end

    // Control state is reset; payload registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rem_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
        byte_reg <= byte_next;
        lor_reg  <= lor_next;
        eot_reg  <= eot_next;
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = lor_reg;
    assign m_tuser  = eot_reg;

endmodule

[src/uri_percent_escaper_top.sv]
// Top level of the URI percent escaper: config register, input register, output stage.
// Path: a byte passes the input register and then the output register to m_tdata.
// Throughput: one output word per cycle while m_tready is high; a literal byte is
// sent as one word, an escaped byte as three, all from the single output register.
// Reset: synchronous active-low aresetn empties both registers and sets escape_mode to 0.
`timescale 1ns / 1ps

module uri_percent_escaper_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,  // escape_mode [2:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // in_byte [7:0]
    input  logic        s_tlast,    // last_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // out_byte [7:0]
    output logic        m_tlast,    // last_of_run
    output logic [0:0]  m_tuser     // end_of_text [0]
);
    import upe_pkg::*;

    logic [2:0] escape_mode_reg;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       ld_ready;
    class_t     cls;
    item_t      item;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_mode_reg <= MODE_URI;
        end else if (cfg_we) begin
            escape_mode_reg <= cfg_wdata;
        end
    end

    // Input register: refills in the same cycle it hands its word on.
    assign s_tready = !in_valid_reg || ld_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (ld_ready) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    upe_classify u_classify (
        .escape_mode (escape_mode_reg),
        .in_byte     (in_byte_reg),
        .cls         (cls)
    );

    // Bundle the held word with its classification for the output stage.
    always_comb begin
        item.in_byte = in_byte_reg;
        item.last_in = in_last_reg;
        item.cls     = cls;
    end

    upe_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ld_valid (in_valid_reg),
        .ld_item  (item),
        .ld_ready (ld_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // End of text only ever rides on the last word of a run.
    a_eot_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("end_of_text set on a word that is not last of run");

    // Inside an escape sequence the next word is ready in the very next cycle.
    a_seq_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("escape sequence interrupted");

    // A word that does not end its run is either the percent sign or a hex digit.
    a_mid_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tdata == PCT_CHAR)
            || (m_tdata >= 8'h30 && m_tdata <= 8'h39)
            || (m_tdata >= 8'h61 && m_tdata <= 8'h66))
        else $error("unexpected character inside an escape sequence");

    // The output is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
